// File: sv/metronome_click_scheduler_macros.svh
// Assertion macros shared by the metronome click scheduler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef METRONOME_CLICK_SCHEDULER_MACROS_SVH
`define METRONOME_CLICK_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

`define MCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define MCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define MCS_ASSERT_IMPL(name, clk, rst, ante, cons)

`define MCS_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: sv/mcs_pkg.sv
// Shared widths, reset values, codes and types of the metronome click scheduler.
// No dependencies.
package mcs_pkg;

   localparam int BPM_W      = 10;
   localparam int BPMEAS_W   = 7;
   localparam int SUB_W      = 5;
   localparam int TIME_W     = 48;
   localparam int VOL_W      = 8;
   localparam int CO_W       = 8;
   localparam int COUNT_W    = 32;
   localparam int KIND_W     = 2;
   localparam int VOICE_W    = 4;

   localparam int DVSR_W     = BPM_W + SUB_W;
   localparam int PMEAS_W    = BPMEAS_W + SUB_W;
   localparam int COTHR_W    = CO_W + SUB_W;
   localparam int DIV_W      = TIME_W;
   localparam int STEP_W     = $clog2(DIV_W + 1);

   localparam int REG_IDX_W  = 3;
   localparam int REG_LSB    = 3;
   localparam int CSR_ADDR_W = REG_IDX_W + REG_LSB;
   localparam int CSR_DATA_W = 64;

   localparam logic [15:0]         MS_PER_MINUTE  = 16'd60000;

   localparam logic [BPM_W-1:0]    BPM_RST        = BPM_W'(120);
   localparam logic [BPMEAS_W-1:0] BPMEAS_RST     = BPMEAS_W'(4);
   localparam logic [SUB_W-1:0]    SUB_RST        = SUB_W'(1);
   localparam logic [TIME_W-1:0]   START_RST      = '0;
   localparam logic [TIME_W-1:0]   STOP_RST       = '0;
   localparam logic [CO_W-1:0]     COUNTOFF_RST   = '0;
   localparam logic [VOL_W-1:0]    REG_VOL_RST    = VOL_W'(255);
   localparam logic [VOL_W-1:0]    CO_VOL_RST     = VOL_W'(255);

   localparam int START_VOICES_DEF = 2;
   localparam int BEAT_VOICES_DEF  = 8;
   localparam int SUB_VOICES_DEF   = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_MEASURE, KIND_BEAT, KIND_SUB, KIND_FINISH
   } mcs_kind_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_BPM, REG_BPMEAS, REG_SUB, REG_START,
      REG_STOP, REG_COUNTOFF, REG_RVOL, REG_CVOL
   } mcs_reg_type;

   typedef struct packed {
      logic [BPM_W-1:0]    bpm;
      logic [BPMEAS_W-1:0] bpmeas;
      logic [SUB_W-1:0]    sub;
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   stop_time;
      logic [CO_W-1:0]     countoff;
      logic [VOL_W-1:0]    reg_vol;
      logic [VOL_W-1:0]    co_vol;
   } mcs_cfg_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] start_time;
   } mcs_rearm_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } mcs_div_ctl_type;

endpackage

// File: sv/mcs_csr.sv
// APB-style configuration registers of the metronome click scheduler.
// Depends on mcs_pkg; drives the config struct and the re-arm strobe.
module mcs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mcs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [mcs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mcs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output mcs_pkg::mcs_cfg_type                cfg,
   output mcs_pkg::mcs_rearm_type              rearm
);
   import mcs_pkg::*;

   mcs_cfg_type cfg_ff;
   mcs_reg_type idx;
   logic        wr;

   assign idx        = mcs_reg_type'(csr_paddr[CSR_ADDR_W-1:REG_LSB]);
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   assign rearm.valid      = wr && (idx == REG_START);
   assign rearm.start_time = csr_pwdata[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bpm        <= BPM_RST;
         cfg_ff.bpmeas     <= BPMEAS_RST;
         cfg_ff.sub        <= SUB_RST;
         cfg_ff.start_time <= START_RST;
         cfg_ff.stop_time  <= STOP_RST;
         cfg_ff.countoff   <= COUNTOFF_RST;
         cfg_ff.reg_vol    <= REG_VOL_RST;
         cfg_ff.co_vol     <= CO_VOL_RST;
      end else if (wr) begin
         case (idx)
            REG_BPM:      cfg_ff.bpm        <= csr_pwdata[BPM_W-1:0];
            REG_BPMEAS:   cfg_ff.bpmeas     <= csr_pwdata[BPMEAS_W-1:0];
            REG_SUB:      cfg_ff.sub        <= csr_pwdata[SUB_W-1:0];
            REG_START:    cfg_ff.start_time <= csr_pwdata[TIME_W-1:0];
            REG_STOP:     cfg_ff.stop_time  <= csr_pwdata[TIME_W-1:0];
            REG_COUNTOFF: cfg_ff.countoff   <= csr_pwdata[CO_W-1:0];
            REG_RVOL:     cfg_ff.reg_vol    <= csr_pwdata[VOL_W-1:0];
            REG_CVOL:     cfg_ff.co_vol     <= csr_pwdata[VOL_W-1:0];
            default:      cfg_ff.bpm        <= cfg_ff.bpm;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_BPM:      csr_prdata = CSR_DATA_W'(cfg_ff.bpm);
         REG_BPMEAS:   csr_prdata = CSR_DATA_W'(cfg_ff.bpmeas);
         REG_SUB:      csr_prdata = CSR_DATA_W'(cfg_ff.sub);
         REG_START:    csr_prdata = CSR_DATA_W'(cfg_ff.start_time);
         REG_STOP:     csr_prdata = CSR_DATA_W'(cfg_ff.stop_time);
         REG_COUNTOFF: csr_prdata = CSR_DATA_W'(cfg_ff.countoff);
         REG_RVOL:     csr_prdata = CSR_DATA_W'(cfg_ff.reg_vol);
         REG_CVOL:     csr_prdata = CSR_DATA_W'(cfg_ff.co_vol);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

// File: sv/mcs_div.sv
// Shared restoring divider: one quotient bit per cycle, MSB-aligned dividend.
// Depends on mcs_pkg and the assertion macro header.
module mcs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  mcs_pkg::mcs_div_ctl_type      ctl,
   input  logic [mcs_pkg::DIV_W-1:0]     dividend,
   input  logic [mcs_pkg::DVSR_W-1:0]    divisor,
   output logic                          done,
   output logic [mcs_pkg::DIV_W-1:0]     quot,
   output logic [mcs_pkg::DVSR_W-1:0]    rem
);
   import mcs_pkg::*;
   `include "metronome_click_scheduler_macros.svh"

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [DIV_W-1:0]  dvd_ff,   dvd_in;
   logic [DIV_W-1:0]  quot_ff,  quot_in;
   logic [DVSR_W-1:0] rem_ff,   rem_in;
   logic [DVSR_W-1:0] dvsr_ff,  dvsr_in;
   logic [DVSR_W:0]   rem_sh;
   logic [DVSR_W:0]   rem_sub;
   logic              ge;
   logic              last_step;

   assign rem_sh    = {rem_ff, dvd_ff[DIV_W-1]};
   assign ge        = rem_sh >= {1'b0, dvsr_ff};
   assign rem_sub   = rem_sh - {1'b0, dvsr_ff};
   assign last_step = busy_ff && (steps_ff == STEP_W'(1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      dvd_in   = dvd_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         steps_in = ctl.steps;
         dvd_in   = dividend;
         dvsr_in  = divisor;
         quot_in  = '0;
         rem_in   = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[DIV_W-2:0], 1'b0};
         quot_in  = {quot_ff[DIV_W-2:0], ge};
         rem_in   = ge ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
         steps_in = steps_ff - STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      steps_ff <= steps_in;
      dvd_ff   <= dvd_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

   `MCS_ASSERT_IMPL(a_start_when_free, clock, reset, ctl.start, !busy_ff)
   `MCS_ASSERT_IMPL(a_divisor_nonzero, clock, reset, ctl.start, divisor != '0)
   `MCS_ASSERT_NEXT(a_last_step_done, clock, reset, last_step, done_ff && !busy_ff)

endmodule

// File: sv/metronome_click_scheduler.sv
// Metronome click scheduler, top level.
// Input channel req_*: one word per poll, carrying the current time in ms.
// Result channel rsp_*: zero or one word per poll (a click or the finished mark).
// Config port csr_*: APB-style, 64-bit data, register i at byte address 8*i;
// writing start_time re-arms the click count, voice slots and finished flag.
// Sequence: a poll with no result passes the idle and check states and frees
// the input; the finished mark passes check and out into the rsp register.
// A click runs the shared restoring divider three times (32 steps for the
// measure position, 12 for the beat position, 48 for the next click time),
// then the out state loads the click into the rsp register and the input is
// freed. The divider produces one quotient bit per cycle.
// One poll is in flight at a time; req_ready is high only while idle.
// A stalled receiver lets the next poll in; a poll that has a result then
// waits with req_ready low until the rsp register is taken.
// Reset: registers take their documented defaults, the schedule starts at
// time 0 with click count 0, and no result is pending.
module metronome_click_scheduler #(
   parameter int START_VOICES = mcs_pkg::START_VOICES_DEF,
   parameter int BEAT_VOICES  = mcs_pkg::BEAT_VOICES_DEF,
   parameter int SUB_VOICES   = mcs_pkg::SUB_VOICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mcs_pkg::TIME_W-1:0]      req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mcs_pkg::KIND_W-1:0]      rsp_click_kind,
   output logic [mcs_pkg::VOICE_W-1:0]     rsp_voice_index,
   output logic [mcs_pkg::VOL_W-1:0]       rsp_volume,
   output logic                            rsp_in_countoff,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import mcs_pkg::*;
   `include "metronome_click_scheduler_macros.svh"

   localparam int SV_W = (START_VOICES > 1) ? $clog2(START_VOICES) : 1;
   localparam int BV_W = (BEAT_VOICES > 1) ? $clog2(BEAT_VOICES) : 1;
   localparam int UV_W = (SUB_VOICES > 1) ? $clog2(SUB_VOICES) : 1;
   localparam int RSP_W = KIND_W + VOICE_W + VOL_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_MODM, ST_MODS, ST_TIME, ST_WTIME, ST_OUT
   } state_type;

   mcs_cfg_type     cfg;
   mcs_rearm_type   rearm;
   mcs_div_ctl_type div_ctl;
   logic [DIV_W-1:0]  div_dvd;
   logic [DVSR_W-1:0] div_dvsr;
   logic              div_done;
   logic [DIV_W-1:0]  div_quot;
   logic [DVSR_W-1:0] div_rem;

   state_type          state_ff,      state_in;
   logic [TIME_W-1:0]  now_ff,        now_in;
   logic [COUNT_W-1:0] count_ff,      count_in;
   logic [TIME_W-1:0]  next_ff,       next_in;
   logic               fin_ff,        fin_in;
   logic [SV_W-1:0]    sslot_ff,      sslot_in;
   logic [BV_W-1:0]    bslot_ff,      bslot_in;
   logic [UV_W-1:0]    uslot_ff,      uslot_in;
   logic               ismeas_ff,     ismeas_in;
   logic               co_ff,         co_in;
   logic [DIV_W-1:0]   prod_ff,       prod_in;
   mcs_kind_type       pkind_ff,      pkind_in;
   logic [VOICE_W-1:0] pvoice_ff,     pvoice_in;
   logic [VOL_W-1:0]   pvol_ff,       pvol_in;
   logic               pco_ff,        pco_in;
   logic               rvalid_ff,     rvalid_in;
   mcs_kind_type       rkind_ff,      rkind_in;
   logic [VOICE_W-1:0] rvoice_ff,     rvoice_in;
   logic [VOL_W-1:0]   rvol_ff,       rvol_in;
   logic               rco_ff,        rco_in;
   logic               out_load;
   logic               rsp_stall;
   logic [RSP_W-1:0]   rsp_word;

   logic [BPM_W-1:0]    bpm_eff;
   logic [BPMEAS_W-1:0] bpmeas_eff;
   logic [SUB_W-1:0]    sub_eff;
   logic [PMEAS_W-1:0]  per_meas;
   logic [DVSR_W-1:0]   dvsr_time;
   logic [COTHR_W-1:0]  co_thr;
   logic [COUNT_W-1:0]  count_inc;
   logic [DIV_W-1:0]    time_prod;
   logic [TIME_W:0]     time_sum;
   logic                stop_hit;

   mcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .rearm       (rearm)
   );

   mcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dvd),
      .divisor  (div_dvsr),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign bpm_eff    = (cfg.bpm == '0) ? BPM_W'(1) : cfg.bpm;
   assign bpmeas_eff = (cfg.bpmeas == '0) ? BPMEAS_W'(1) : cfg.bpmeas;
   assign sub_eff    = (cfg.sub == '0) ? SUB_W'(1) : cfg.sub;
   assign per_meas   = PMEAS_W'(bpmeas_eff) * PMEAS_W'(sub_eff);
   assign dvsr_time  = DVSR_W'(bpm_eff) * DVSR_W'(sub_eff);
   assign co_thr     = COTHR_W'(cfg.countoff) * COTHR_W'(sub_eff);
   assign count_inc  = count_ff + COUNT_W'(1);
   assign time_prod  = DIV_W'(count_inc) * DIV_W'(MS_PER_MINUTE);
   assign time_sum   = {1'b0, cfg.start_time} + {1'b0, div_quot};
   assign stop_hit   = (cfg.stop_time != '0) && (now_ff >= cfg.stop_time);

   always_comb begin
      state_in  = state_ff;
      now_in    = now_ff;
      count_in  = count_ff;
      next_in   = next_ff;
      fin_in    = fin_ff;
      sslot_in  = sslot_ff;
      bslot_in  = bslot_ff;
      uslot_in  = uslot_ff;
      ismeas_in = ismeas_ff;
      co_in     = co_ff;
      prod_in   = prod_ff;
      pkind_in  = pkind_ff;
      pvoice_in = pvoice_ff;
      pvol_in   = pvol_ff;
      pco_in    = pco_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      rkind_in  = rkind_ff;
      rvoice_in = rvoice_ff;
      rvol_in   = rvol_ff;
      rco_in    = rco_ff;
      out_load  = 1'b0;

      div_ctl.start = 1'b0;
      div_ctl.steps = STEP_W'(COUNT_W);
      div_dvd       = {count_ff, {(DIV_W-COUNT_W){1'b0}}};
      div_dvsr      = DVSR_W'(per_meas);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_ms;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (fin_ff) begin
               state_in = ST_IDLE;
            end else if (stop_hit) begin
               fin_in    = 1'b1;
               pkind_in  = KIND_FINISH;
               pvoice_in = '0;
               pvol_in   = '0;
               pco_in    = 1'b0;
               state_in  = ST_OUT;
            end else if (now_ff < next_ff) begin
               state_in = ST_IDLE;
            end else begin
               div_ctl.start = 1'b1;
               co_in         = count_ff < COUNT_W'(co_thr);
               state_in      = ST_MODM;
            end
         end
         ST_MODM: begin
            div_ctl.steps = STEP_W'(PMEAS_W);
            div_dvd       = {div_rem[PMEAS_W-1:0], {(DIV_W-PMEAS_W){1'b0}}};
            div_dvsr      = DVSR_W'(sub_eff);
            if (div_done) begin
               div_ctl.start = 1'b1;
               ismeas_in     = (div_rem == '0);
               state_in      = ST_MODS;
            end
         end
         ST_MODS: begin
            if (div_done) begin
               if (ismeas_ff) begin
                  pkind_in  = KIND_MEASURE;
                  pvoice_in = VOICE_W'(sslot_ff);
                  sslot_in  = (sslot_ff == SV_W'(START_VOICES - 1)) ? '0 :
                              sslot_ff + SV_W'(1);
               end else if (div_rem == '0) begin
                  pkind_in  = KIND_BEAT;
                  pvoice_in = VOICE_W'(bslot_ff);
                  bslot_in  = (bslot_ff == BV_W'(BEAT_VOICES - 1)) ? '0 :
                              bslot_ff + BV_W'(1);
               end else begin
                  pkind_in  = KIND_SUB;
                  pvoice_in = VOICE_W'(uslot_ff);
                  uslot_in  = (uslot_ff == UV_W'(SUB_VOICES - 1)) ? '0 :
                              uslot_ff + UV_W'(1);
               end
               pvol_in  = co_ff ? cfg.co_vol : cfg.reg_vol;
               pco_in   = co_ff;
               count_in = count_inc;
               prod_in  = time_prod;
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            div_ctl.start = 1'b1;
            div_ctl.steps = STEP_W'(DIV_W);
            div_dvd       = prod_ff;
            div_dvsr      = dvsr_time;
            state_in      = ST_WTIME;
         end
         ST_WTIME: begin
            if (div_done) begin
               next_in  = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rvalid_ff || rsp_ready) begin
               out_load  = 1'b1;
               rvalid_in = 1'b1;
               rkind_in  = pkind_ff;
               rvoice_in = pvoice_ff;
               rvol_in   = pvol_ff;
               rco_in    = pco_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rearm.valid) begin
         count_in = '0;
         next_in  = rearm.start_time;
         fin_in   = 1'b0;
         sslot_in = '0;
         bslot_in = '0;
         uslot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         next_ff   <= START_RST;
         fin_ff    <= 1'b0;
         sslot_ff  <= '0;
         bslot_ff  <= '0;
         uslot_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         next_ff   <= next_in;
         fin_ff    <= fin_in;
         sslot_ff  <= sslot_in;
         bslot_ff  <= bslot_in;
         uslot_ff  <= uslot_in;
         rvalid_ff <= rvalid_in;
      end
      now_ff    <= now_in;
      ismeas_ff <= ismeas_in;
      co_ff     <= co_in;
      prod_ff   <= prod_in;
      pkind_ff  <= pkind_in;
      pvoice_ff <= pvoice_in;
      pvol_ff   <= pvol_in;
      pco_ff    <= pco_in;
      rkind_ff  <= rkind_in;
      rvoice_ff <= rvoice_in;
      rvol_ff   <= rvol_in;
      rco_ff    <= rco_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rvalid_ff;
   assign rsp_click_kind  = rkind_ff;
   assign rsp_voice_index = rvoice_ff;
   assign rsp_volume      = rvol_ff;
   assign rsp_in_countoff = rco_ff;
   assign rsp_stall       = rvalid_ff && !rsp_ready;
   assign rsp_word        = {rkind_ff, rvoice_ff, rvol_ff, rco_ff};

   `MCS_ASSERT_NEXT(a_one_poll_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `MCS_ASSERT_IMPL(a_no_click_when_finished, clock, reset, out_load && pkind_ff != KIND_FINISH, !fin_ff)
   `MCS_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rvalid_ff && $stable(rsp_word))

endmodule
